>>> sv/nrmq_pkg.sv
// Shared types and constants for the nucleotide range minimum query block.
// No dependencies; imported by nrmq_prefix_mem, nrmq_min_sel and the top level.
`timescale 1ns / 1ps

package nrmq_pkg;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_QUERY  = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CHAR  = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_RANGE = 2'd3
  } status_t;

  localparam logic [7:0] SYM_A = 8'h41;
  localparam logic [7:0] SYM_C = 8'h43;
  localparam logic [7:0] SYM_G = 8'h47;
  localparam logic [7:0] SYM_T = 8'h54;

  localparam int NUM_BASES = 4;
  localparam logic [2:0] SLOT_NONE = 3'd4;

  // Count slot 0..3 for A, C, G, T; SLOT_NONE for anything else.
  function automatic logic [2:0] symbol_slot(input logic [7:0] sym);
    logic [2:0] slot;
    case (sym)
      SYM_A:   slot = 3'd0;
      SYM_C:   slot = 3'd1;
      SYM_G:   slot = 3'd2;
      SYM_T:   slot = 3'd3;
      default: slot = SLOT_NONE;
    endcase
    return slot;
  endfunction

endpackage

>>> sv/nucleotide_range_min_query.sv
// Nucleotide range minimum query, answered from stored prefix counts.
// Depends on nrmq_pkg, nrmq_prefix_mem and nrmq_min_sel.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+------------------------------------------
//   s_      | in  | s_tvalid/s_tready  | tuser: mode; tdata: symbol, start, end
//   m_      | out | m_tvalid/m_tready  | tuser: status; tdata: least_impact
//
// One request per cycle sustained while the output is not stalled; the store read
// registers and the request stage take a request as it is accepted, and the answer
// then passes from them into the output register.
// Appends write the store in the cycle they are accepted, so a following query
// always sees them. Reset clears the length and running counts; entry zero of
// the store reads as zero by address, so no clearing pass is run. A stalled
// output holds one result and one request in flight, then drops s_tready.
`timescale 1ns / 1ps

module nucleotide_range_min_query
  import nrmq_pkg::*;
#(
  parameter int MAX_LEN = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // [1:0] mode
  input  logic [31:0] s_tdata,   // [7:0] symbol, [17:8] range_start, [27:18] range_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [1:0]  m_tuser,   // [1:0] status
  output logic [7:0]  m_tdata    // [2:0] least_impact
);

  localparam int LW    = $clog2(MAX_LEN + 1);
  localparam int DEPTH = MAX_LEN + 1;
  localparam int DW    = NUM_BASES * LW;
  localparam int CW    = (LW > 11) ? LW : 11;

  mode_t       mode;
  logic [7:0]  symbol;
  logic [9:0]  range_start;
  logic [9:0]  range_end;
  logic [2:0]  slot;
  logic        accept;
  logic        s1_go;

  logic [LW-1:0] seq_len;
  logic [LW-1:0] run_cnt [NUM_BASES];
  logic [LW-1:0] cnt_next [NUM_BASES];
  logic [DW-1:0] wr_data;

  logic          wr_en;
  logic          rd_en;
  logic [DW-1:0] rd_data_a;
  logic [DW-1:0] rd_data_b;
  logic [2:0]    impact;

  logic          s1_valid;
  logic          s1_query;
  status_t       s1_status;
  status_t       status_next;

  assign mode        = mode_t'(s_tuser);
  assign symbol      = s_tdata[7:0];
  assign range_start = s_tdata[17:8];
  assign range_end   = s_tdata[27:18];
  assign slot        = symbol_slot(symbol);

  assign s1_go    = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || s1_go;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    status_next = ST_OK;
    case (mode)
      MODE_APPEND: begin
        if (slot == SLOT_NONE) begin
          status_next = ST_BAD_CHAR;
        end else if (seq_len >= LW'(MAX_LEN)) begin
          status_next = ST_FULL;
        end
      end
      MODE_QUERY: begin
        if (range_start > range_end || CW'(range_end) >= CW'(seq_len)) begin
          status_next = ST_BAD_RANGE;
        end
      end
      default: status_next = ST_OK;
    endcase
  end

  always_comb begin
    for (int k = 0; k < NUM_BASES; k++) begin
      cnt_next[k] = run_cnt[k] + LW'(slot == 3'(k));
      wr_data[k*LW +: LW] = cnt_next[k];
    end
  end

  assign wr_en = accept && (mode == MODE_APPEND) && (status_next == ST_OK);
  assign rd_en = accept && (mode == MODE_QUERY);

  nrmq_prefix_mem #(
    .DEPTH (DEPTH),
    .AW    (LW),
    .DW    (DW)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (seq_len + LW'(1)),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr_a (LW'(range_start)),
    .rd_addr_b (LW'({1'b0, range_end} + 11'd1)),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  nrmq_min_sel #(
    .CNTW (LW)
  ) u_sel (
    .lo_counts    (rd_data_a),
    .hi_counts    (rd_data_b),
    .least_impact (impact)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_len  <= '0;
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
      for (int k = 0; k < NUM_BASES; k++) begin
        run_cnt[k] <= '0;
      end
    end else begin
      if (accept) begin
        if (wr_en) begin
          seq_len <= seq_len + LW'(1);
          for (int k = 0; k < NUM_BASES; k++) begin
            run_cnt[k] <= cnt_next[k];
          end
        end else if (mode == MODE_CLEAR) begin
          seq_len <= '0;
          for (int k = 0; k < NUM_BASES; k++) begin
            run_cnt[k] <= '0;
          end
        end
        s1_valid  <= 1'b1;
        s1_query  <= (mode == MODE_QUERY) && (status_next == ST_OK);
        s1_status <= status_next;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end

      // Advance the pending request into the output register.
      if (s1_valid && s1_go) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {5'd0, s1_query ? impact : 3'd0};
        m_tuser  <= s1_status;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

>>> sv/nrmq_prefix_mem.sv
// Prefix count store: one write port, two registered read ports.
// Entry zero is never written and always reads as zero. Uses nrmq_pkg.
`timescale 1ns / 1ps

module nrmq_prefix_mem
  import nrmq_pkg::*;
#(
  parameter int DEPTH = 1025,
  parameter int AW    = 11,
  parameter int DW    = 44
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  output logic [DW-1:0] rd_data_a,
  output logic [DW-1:0] rd_data_b
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] raw_a;
  logic [DW-1:0] raw_b;
  logic          zero_a;
  logic          zero_b;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      raw_a  <= mem[rd_addr_a];
      raw_b  <= mem[rd_addr_b];
      zero_a <= (rd_addr_a == '0);
      zero_b <= (rd_addr_b == '0);
    end
  end

  // Entry zero holds the empty prefix.
  assign rd_data_a = zero_a ? '0 : raw_a;
  assign rd_data_b = zero_b ? '0 : raw_b;

endmodule

>>> sv/nrmq_min_sel.sv
// Lowest impact present between two prefix count entries.
// Compares the four base counts and picks the first that differs. Uses nrmq_pkg.
`timescale 1ns / 1ps

module nrmq_min_sel
  import nrmq_pkg::*;
#(
  parameter int CNTW = 11
) (
  input  logic [NUM_BASES*CNTW-1:0] lo_counts,
  input  logic [NUM_BASES*CNTW-1:0] hi_counts,
  output logic [2:0]                least_impact
);

  always_comb begin
    least_impact = 3'd0;
    // Scan from T down so the lowest differing base wins.
    for (int k = NUM_BASES - 1; k >= 0; k--) begin
      if (hi_counts[k*CNTW +: CNTW] != lo_counts[k*CNTW +: CNTW]) begin
        least_impact = 3'(k + 1);
      end
    end
  end

endmodule
